// ===== rtl/core/line_address_table_lookup_macros.svh =====
// Assertion macros shared by the checker of line_address_table_lookup.
// No dependencies; included by bare file name.
`ifndef LINE_ADDRESS_TABLE_LOOKUP_MACROS_SVH
`define LINE_ADDRESS_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication, muted during reset
`define LAT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line table check failed");

// next-cycle implication, muted during reset
`define LAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line table check failed");

// next-cycle implication, live during reset
`define LAT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line table check failed");

`endif

// ===== rtl/core/lat_pkg.sv =====
// Package of the line/address table lookup block: widths, codes, FSM state,
// controller/datapath command and status types. No dependencies.
package lat_pkg;

  localparam int LINE_W            = 20;
  localparam int ADDR_W            = 20;
  localparam int DELTA_W           = 8;
  localparam int TABLE_ENTRIES_DEF = 256;

  localparam logic [LINE_W-1:0] FIRST_LINE_RST = LINE_W'(1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_Q0,
    ST_SCAN,
    ST_NEXT,
    ST_FINISH
  } lat_state_t;

  typedef struct packed {
    logic capture;    // latch the accepted input transaction
    logic append;     // store one appended entry
    logic q_start;    // check entry zero, start the scan
    logic scan_step;  // compare one stored entry
    logic take_next;  // capture the entry after the match
    logic load_out;   // move the result into the output register
  } lat_cmd_t;

  typedef struct packed {
    logic req_op;      // op of the offered input transaction
    logic match0;      // entry zero holds the query line
    logic match_k;     // stored entry under scan holds the query line
    logic count_zero;  // nothing appended yet
    logic at_last;     // entry under scan is the last one
    logic out_free;    // output register can take a result
  } lat_status_t;

endpackage

// ===== rtl/core/lat_channels.sv =====
// Channel interfaces of the line/address table lookup block.
// Depends on lat_pkg for field widths.
interface lat_req_if import lat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [DELTA_W-1:0] addr_delta;
  logic [DELTA_W-1:0] line_delta;
  logic [LINE_W-1:0]  query_line;

  modport source (output valid, output op, output addr_delta, output line_delta,
                  output query_line, input ready);
  modport sink   (input valid, input op, input addr_delta, input line_delta,
                  input query_line, output ready);
endinterface

interface lat_rsp_if import lat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_addr;
  logic [LINE_W-1:0] prev_line;
  logic              has_next;
  logic [LINE_W-1:0] next_line;
  logic              overflowed;

  modport source (output valid, output found, output match_addr, output prev_line,
                  output has_next, output next_line, output overflowed, input ready);
  modport sink   (input valid, input found, input match_addr, input prev_line,
                  input has_next, input next_line, input overflowed, output ready);
endinterface

interface lat_cfg_if import lat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] first_line;

  modport source (output valid, output first_line, input ready);
  modport sink   (input valid, input first_line, output ready);
endinterface

// ===== rtl/core/line_address_table_lookup.sv =====
// Top level of the line/address table lookup block.
// Depends on lat_pkg, lat_channels, lat_ram, lat_ctrl and lat_dp.
//
//  channel | modport | moves
//  --------+---------+-----------------------------------------------------
//  req     | sink    | append (deltas) or query (line), one per transaction
//  rsp     | source  | one lookup result per query transaction
//  cfg     | sink    | first_line write, always ready
//
// Append: accept, then write into the table RAM.
// Query: check entry zero, then scan the stored entries up to the first match
//   or the last entry, then capture the entry after the match if one follows,
//   then load the result. The scan compares one stored entry per cycle
//   through the single read port of the table RAM.
// Reset: synchronous, no clearing pass; unwritten table slots may be read, but that data is never used.
// A finished result waits in the output register while the next transaction
//   is accepted; a query only stalls at its end while that register is full.
module line_address_table_lookup import lat_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lat_req_if.sink    req,
  lat_rsp_if.source  rsp,
  lat_cfg_if.sink    cfg
);

  lat_cmd_t    cmd;
  lat_status_t status;

  // configuration writes are always taken, so the port never stalls
  assign cfg.ready = 1'b1;

  lat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lat_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_op         (req.op),
    .req_addr_delta (req.addr_delta),
    .req_line_delta (req.line_delta),
    .req_query_line (req.query_line),
    .cfg_we         (cfg.valid),
    .cfg_first_line (cfg.first_line),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_found      (rsp.found),
    .out_match_addr (rsp.match_addr),
    .out_prev_line  (rsp.prev_line),
    .out_has_next   (rsp.has_next),
    .out_next_line  (rsp.next_line),
    .out_overflowed (rsp.overflowed),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

// ===== rtl/core/lat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lat_ctrl.sv =====
// Controller FSM of the line/address table lookup block.
// Depends on lat_pkg (state, command and status types).
module lat_ctrl import lat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  lat_status_t status,
  output lat_cmd_t    cmd
);

  lat_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (status.req_op == OP_QUERY) ? ST_Q0 : ST_APPEND;
        end
      end
      ST_APPEND: state_next = ST_IDLE;
      ST_Q0: begin
        if (status.count_zero) begin
          state_next = ST_FINISH;
        end else if (status.match0) begin
          state_next = ST_NEXT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.match_k) begin
          state_next = status.at_last ? ST_FINISH : ST_NEXT;
        end else if (status.at_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_NEXT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_APPEND: cmd.append    = 1'b1;
      ST_Q0:     cmd.q_start   = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_NEXT:   cmd.take_next = 1'b1;
      ST_FINISH: cmd.load_out  = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/lat_dp.sv =====
// Datapath of the line/address table lookup block: running sums, table RAM,
// scan registers and output register. Depends on lat_pkg and lat_ram.
module lat_dp import lat_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input payload
  input  logic               req_op,
  input  logic [DELTA_W-1:0] req_addr_delta,
  input  logic [DELTA_W-1:0] req_line_delta,
  input  logic [LINE_W-1:0]  req_query_line,
  // configuration write
  input  logic               cfg_we,
  input  logic [LINE_W-1:0]  cfg_first_line,
  // result channel
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_found,
  output logic [ADDR_W-1:0]  out_match_addr,
  output logic [LINE_W-1:0]  out_prev_line,
  output logic               out_has_next,
  output logic [LINE_W-1:0]  out_next_line,
  output logic               out_overflowed,
  // controller link
  input  lat_cmd_t           cmd,
  output lat_status_t        status
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ENT_W = LINE_W + ADDR_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // configuration and table state
  logic [LINE_W-1:0] first_line;
  logic [IDX_W-1:0]  entry_count;
  logic [LINE_W-1:0] running_line;
  logic [ADDR_W-1:0] running_addr;
  logic              overflow_flag;

  // captured input transaction
  logic [DELTA_W-1:0] addr_delta;
  logic [DELTA_W-1:0] line_delta;
  logic [LINE_W-1:0]  query_line;

  // scan state and result under construction
  logic [IDX_W-1:0]  k;
  logic [LINE_W-1:0] prev_line;
  logic              res_found;
  logic [ADDR_W-1:0] res_addr;
  logic [LINE_W-1:0] res_prev;
  logic              res_has_next;
  logic [LINE_W-1:0] res_next;

  logic [LINE_W:0]   sum_line;
  logic [ADDR_W:0]   sum_addr;
  logic [LINE_W-1:0] sat_line;
  logic [ADDR_W-1:0] sat_addr;
  logic              table_full;

  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [ENT_W-1:0]  rdata;
  logic [LINE_W-1:0] rd_line;
  logic [ADDR_W-1:0] rd_addr;

  assign sum_line   = {1'b0, running_line} + (LINE_W+1)'(line_delta);
  assign sum_addr   = {1'b0, running_addr} + (ADDR_W+1)'(addr_delta);
  assign sat_line   = sum_line[LINE_W] ? '1 : sum_line[LINE_W-1:0];
  assign sat_addr   = sum_addr[ADDR_W] ? '1 : sum_addr[ADDR_W-1:0];
  assign table_full = (entry_count == IDX_LAST);

  assign waddr   = entry_count + IDX_ONE;
  // scan reads one entry ahead, so the entry after a match is already on its way
  assign raddr   = cmd.q_start ? IDX_ONE : (k + IDX_ONE);
  assign rd_line = rdata[ENT_W-1 -: LINE_W];
  assign rd_addr = rdata[ADDR_W-1:0];

  lat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.append && !table_full),
    .waddr (waddr),
    .wdata ({sat_line, sat_addr}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_line    <= FIRST_LINE_RST;
      entry_count   <= '0;
      running_line  <= FIRST_LINE_RST;
      running_addr  <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        first_line <= cfg_first_line;
        if (entry_count == '0) begin
          running_line <= cfg_first_line;
        end
      end
      if (cmd.append) begin
        if (table_full) begin
          overflow_flag <= 1'b1;
        end else begin
          running_line <= sat_line;
          running_addr <= sat_addr;
          entry_count  <= entry_count + IDX_ONE;
          if (sum_line[LINE_W] || sum_addr[ADDR_W]) begin
            overflow_flag <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_delta <= req_addr_delta;
      line_delta <= req_line_delta;
      query_line <= req_query_line;
    end
    if (cmd.q_start) begin
      res_found    <= status.match0;
      res_addr     <= '0;
      res_prev     <= status.match0 ? query_line : '0;
      res_has_next <= 1'b0;
      res_next     <= '0;
      prev_line    <= first_line;
      k            <= IDX_ONE;
    end
    if (cmd.scan_step) begin
      if (status.match_k) begin
        res_found <= 1'b1;
        res_addr  <= rd_addr;
        res_prev  <= prev_line;
      end else begin
        prev_line <= rd_line;
        k         <= k + IDX_ONE;
      end
    end
    if (cmd.take_next) begin
      res_has_next <= 1'b1;
      res_next     <= rd_line;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found      <= res_found;
      out_match_addr <= res_addr;
      out_prev_line  <= res_prev;
      out_has_next   <= res_has_next;
      out_next_line  <= res_next;
      out_overflowed <= overflow_flag;
    end
  end

  always_comb begin
    status.req_op     = req_op;
    status.match0     = (first_line == query_line);
    status.match_k    = (rd_line == query_line);
    status.count_zero = (entry_count == '0) && !(first_line == query_line) ? 1'b1
                      : (entry_count == '0);
    status.at_last    = (k == entry_count);
    status.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/lat_checker.sv =====
// Port-level checker of line_address_table_lookup, bound to the top level.
// Depends on lat_pkg and line_address_table_lookup_macros.svh.
`include "line_address_table_lookup_macros.svh"

module lat_checker import lat_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              found,
  input logic [ADDR_W-1:0] match_addr,
  input logic [LINE_W-1:0] prev_line,
  input logic              has_next,
  input logic [LINE_W-1:0] next_line
);

  logic miss_payload_zero;

  assign miss_payload_zero = (match_addr == '0) && (prev_line == '0) && !has_next;

  // a result waiting for the sink stays offered
  `LAT_ASSERT_NEXT(a_rsp_hold, clk, rst, out_valid && !out_ready, out_valid)
  // no result appears straight out of reset
  `LAT_ASSERT_NEXT_ALWAYS(a_rst_quiet, clk, rst, !out_valid)
  // a miss carries an all-zero payload apart from the overflow flag
  `LAT_ASSERT_IMPLY(a_miss_zero, clk, rst, out_valid && !found, miss_payload_zero)
  // no following entry means no next line
  `LAT_ASSERT_IMPLY(a_next_zero, clk, rst, out_valid && !has_next, next_line == '0)

endmodule

bind line_address_table_lookup lat_checker u_lat_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .found      (rsp.found),
  .match_addr (rsp.match_addr),
  .prev_line  (rsp.prev_line),
  .has_next   (rsp.has_next),
  .next_line  (rsp.next_line)
);
